// ===== rtl/core/btc_pkg.sv =====
// Shared types, register codes and helpers for the block transposition cipher unit.
`default_nettype none

package btc_pkg;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned KEY_NIB    = 16;
  localparam int unsigned NIB_W      = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CHAR_W-1:0] SPACE_CHAR      = 8'd32;
  localparam logic [LEN_W-1:0]  LEN_RESET       = 5'd16;
  localparam logic [KEY_W-1:0]  KEY_RESET       = 64'hFEDC_BA98_7654_3210;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_LENGTH = 1'b0,
    REG_KEY          = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    CMD_BLOCK = 1'b0,
    CMD_ERROR = 1'b1
  } cmd_kind_e;

  // Clamp the programmed length into 1..max_len.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len,
                                               input logic [LEN_W-1:0] max_len);
    logic [LEN_W-1:0] r;
    r = len;
    if (r == '0) begin
      r = LEN_W'(1);
    end
    if (r > max_len) begin
      r = max_len;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/btc_front.sv =====
// Front end: accept items, drop spaces, fill the block store, issue block and error commands.
`default_nettype none

module btc_front #(
  parameter int unsigned MAX_BLOCK = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [btc_pkg::CHAR_W-1:0]    char_in_i,
  input  wire logic                          end_of_line_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [btc_pkg::LEN_W-1:0]     block_length_i,
  input  wire logic                          q_full_i,
  output logic                               push_o,
  output btc_pkg::cmd_kind_e                 push_kind_o,
  output logic [MAX_BLOCK-1:0][btc_pkg::CHAR_W-1:0] push_bank_o
);
  import btc_pkg::*;

  localparam int unsigned IDX_W  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int unsigned FILL_W = $clog2(MAX_BLOCK + 1);

  logic [MAX_BLOCK-1:0][CHAR_W-1:0] store_q;
  logic [MAX_BLOCK-1:0][CHAR_W-1:0] bank;
  logic [FILL_W-1:0]                fill_q, fill_d;
  logic [LEN_W-1:0]                 len;
  logic [LEN_W-1:0]                 fill_next;
  logic                             accept;
  logic                             is_char;
  logic                             full_block;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & in_ready_o;
  assign is_char    = ~end_of_line_i & (char_in_i != SPACE_CHAR);
  assign len        = eff_len(block_length_i, LEN_W'(MAX_BLOCK));
  assign fill_next  = LEN_W'(fill_q) + LEN_W'(1);
  assign full_block = fill_next >= len;

  // Store image including the character arriving now.
  always_comb begin
    bank = store_q;
    bank[fill_q[IDX_W-1:0]] = char_in_i;
  end

  always_comb begin
    fill_d      = fill_q;
    push_o      = 1'b0;
    push_kind_o = CMD_BLOCK;
    if (accept) begin
      if (end_of_line_i) begin
        if (fill_q != '0) begin
          push_o      = 1'b1;
          push_kind_o = CMD_ERROR;
          fill_d      = '0;
        end
      end else if (is_char) begin
        if (full_block) begin
          push_o = 1'b1;
          fill_d = '0;
        end else begin
          fill_d = FILL_W'(fill_next);
        end
      end
    end
  end

  assign push_bank_o = bank;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_char) begin
      store_q[fill_q[IDX_W-1:0]] <= char_in_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/btc_queue.sv =====
// Two-entry command queue between front and back end; each entry carries a block snapshot.
`default_nettype none

module btc_queue #(
  parameter int unsigned MAX_BLOCK = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      push_i,
  input  wire btc_pkg::cmd_kind_e                        push_kind_i,
  input  wire logic [MAX_BLOCK-1:0][btc_pkg::CHAR_W-1:0] push_bank_i,
  output logic                                           full_o,
  input  wire logic                                      pop_i,
  output logic                                           head_valid_o,
  output btc_pkg::cmd_kind_e                             head_kind_o,
  output logic [MAX_BLOCK-1:0][btc_pkg::CHAR_W-1:0]      head_bank_o
);
  import btc_pkg::*;

  localparam int unsigned DEPTH = 2;

  cmd_kind_e                        kind_q [DEPTH];
  logic [MAX_BLOCK-1:0][CHAR_W-1:0] bank_q [DEPTH];
  logic                             wr_ptr_q, rd_ptr_q;
  logic [1:0]                       count_q, count_d;
  logic                             do_push, do_pop;

  assign full_o       = (count_q == 2'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_kind_o  = kind_q[rd_ptr_q];
  assign head_bank_o  = bank_q[rd_ptr_q];
  assign do_push      = push_i & ~full_o;
  assign do_pop       = pop_i & head_valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      kind_q[wr_ptr_q] <= push_kind_i;
      bank_q[wr_ptr_q] <= push_bank_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/btc_back.sv =====
// Back end: walk the key over a queued block and drive the output register.
`default_nettype none

module btc_back #(
  parameter int unsigned MAX_BLOCK = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      head_valid_i,
  input  wire btc_pkg::cmd_kind_e                        head_kind_i,
  input  wire logic [MAX_BLOCK-1:0][btc_pkg::CHAR_W-1:0] head_bank_i,
  output logic                                           pop_o,
  input  wire logic [btc_pkg::LEN_W-1:0]                 block_length_i,
  input  wire logic [btc_pkg::KEY_W-1:0]                 key_i,
  output logic [btc_pkg::CHAR_W-1:0]                     char_out_o,
  output logic                                           block_last_o,
  output logic                                           length_error_o,
  output logic                                           out_valid_o,
  input  wire logic                                      out_ready_i
);
  import btc_pkg::*;

  localparam int unsigned IDX_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

  logic [KEY_NIB-1:0][NIB_W-1:0] key_nib;
  logic [IDX_W-1:0]              pos_q, pos_d;
  logic [LEN_W-1:0]              len;
  logic [NIB_W-1:0]              src;
  logic [CHAR_W-1:0]             src_char;
  logic                          last_pos;
  logic                          load;
  logic                          out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]             char_q, char_d;
  logic                          last_q, last_d;
  logic                          err_q, err_d;

  assign key_nib  = key_i;
  assign len      = eff_len(block_length_i, LEN_W'(MAX_BLOCK));
  assign src      = key_nib[NIB_W'(pos_q)];
  assign last_pos = (LEN_W'(pos_q) + LEN_W'(1)) == len;
  assign load     = head_valid_i & (~out_valid_q | out_ready_i);

  // Entries past the store depth were never written: read them as zero.
  always_comb begin
    src_char = '0;
    if ({1'b0, src} < (NIB_W + 1)'(MAX_BLOCK)) begin
      src_char = head_bank_i[src[IDX_W-1:0]];
    end
  end

  always_comb begin
    pos_d       = pos_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    char_d      = char_q;
    last_d      = last_q;
    err_d       = err_q;
    if (load) begin
      out_valid_d = 1'b1;
      case (head_kind_i)
        CMD_ERROR: begin
          char_d = '0;
          last_d = 1'b1;
          err_d  = 1'b1;
          pop_o  = 1'b1;
        end
        CMD_BLOCK: begin
          char_d = src_char;
          last_d = last_pos;
          err_d  = 1'b0;
          if (last_pos) begin
            pop_o = 1'b1;
            pos_d = '0;
          end else begin
            pos_d = pos_q + IDX_W'(1);
          end
        end
        default: begin
          out_valid_d = out_valid_q & ~out_ready_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
    err_q  <= err_d;
  end

  assign out_valid_o    = out_valid_q;
  assign char_out_o     = char_q;
  assign block_last_o   = last_q;
  assign length_error_o = err_q;

endmodule

`default_nettype wire

// ===== rtl/core/block_transposition_cipher_unit.sv =====
// Top level of the block transposition cipher unit: config registers, front, queue, back.
`default_nettype none

// Streaming block transposition cipher. Characters enter one item per cycle on the
// input channel; spaces are dropped and the rest fill a block of block_length
// characters (register 0, clamped to 1..MAX_BLOCK). When a block fills, a snapshot
// of the whole store goes into a two-entry command queue and the back end emits it
// as block_length result items, one per cycle, where output position k carries the
// stored character at the index held in nibble k of key_permutation (register 1);
// block_last marks the final item. An end-of-line item arriving on a partial block
// queues one error item (char_out zero, block_last and length_error set) and
// clears the block; on an empty block it produces nothing. Input accepts one item
// per cycle as long as the command queue has room; the back end drains one result
// per cycle while out_ready_i is high, and a command's first result reaches the output
// through the queue entry and the output register. A command leaves the queue when
// its last result enters the output register, so the input stalls while the queue
// holds two commands: the one being emitted and one waiting behind it. Registers are
// written through cfg_we_i/cfg_index_i/cfg_data_i; the user must write them only while
// the unit is idle, as the unit does not enforce it. Block length is read while blocks
// fill and are emitted, the key while a block is emitted.

module block_transposition_cipher_unit #(
  parameter int unsigned MAX_BLOCK = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [btc_pkg::CHAR_W-1:0]        char_in_i,
  input  wire logic                              end_of_line_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  output logic [btc_pkg::CHAR_W-1:0]             char_out_o,
  output logic                                   block_last_o,
  output logic                                   length_error_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [btc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [btc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import btc_pkg::*;

  logic [LEN_W-1:0]                 block_length_q;
  logic [KEY_W-1:0]                 key_q;
  logic                             q_full;
  logic                             push;
  cmd_kind_e                        push_kind;
  logic [MAX_BLOCK-1:0][CHAR_W-1:0] push_bank;
  logic                             pop;
  logic                             head_valid;
  cmd_kind_e                        head_kind;
  logic [MAX_BLOCK-1:0][CHAR_W-1:0] head_bank;

  // Configuration registers: plain write, no read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_length_q <= LEN_RESET;
      key_q          <= KEY_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_BLOCK_LENGTH: begin
          block_length_q <= cfg_data_i[LEN_W-1:0];
        end
        REG_KEY: begin
          key_q <= cfg_data_i[KEY_W-1:0];
        end
        default: begin
          block_length_q <= block_length_q;
        end
      endcase
    end
  end

  // Accept and classify items, hold the partial block.
  btc_front #(
    .MAX_BLOCK(MAX_BLOCK)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .char_in_i     (char_in_i),
    .end_of_line_i (end_of_line_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .block_length_i(block_length_q),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_kind_o   (push_kind),
    .push_bank_o   (push_bank)
  );

  // Decouple filling from emission.
  btc_queue #(
    .MAX_BLOCK(MAX_BLOCK)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_kind_i (push_kind),
    .push_bank_i (push_bank),
    .full_o      (q_full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_kind_o (head_kind),
    .head_bank_o (head_bank)
  );

  // Permute and emit one result item per cycle while the output is not stalled.
  btc_back #(
    .MAX_BLOCK(MAX_BLOCK)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_kind_i   (head_kind),
    .head_bank_i   (head_bank),
    .pop_o         (pop),
    .block_length_i(block_length_q),
    .key_i         (key_q),
    .char_out_o    (char_out_o),
    .block_last_o  (block_last_o),
    .length_error_o(length_error_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i)
  );

endmodule

`default_nettype wire

// ===== sim/block_transposition_cipher_unit_tb.sv =====
// Testbench for the block transposition cipher unit: directed corner cases, then random text.
module block_transposition_cipher_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import btc_pkg::*;

  localparam int unsigned MAX_BLOCK   = 16;
  localparam int unsigned MAX_GAP     = 13;
  // Command queue plus output register; pad generously before touching registers.
  localparam int unsigned DRAIN_SLACK = 20;
  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 24;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              err;
  } cipher_out_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic [CHAR_W-1:0]     char_in_i;
  logic                  end_of_line_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [CHAR_W-1:0]     char_out_o;
  logic                  block_last_o;
  logic                  length_error_o;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Shadow copy of the unit's state and registers, advanced on every accepted item.
  logic [CHAR_W-1:0] shadow_store [KEY_NIB];
  logic [LEN_W-1:0]  shadow_fill;
  logic [LEN_W-1:0]  shadow_len;
  logic [KEY_W-1:0]  shadow_key;

  // Ciphertext items predicted but not yet seen on the output channel.
  cipher_out_t pending_cipher [$];
  int unsigned mismatches;
  // Clear to run both channels without gaps or stalls.
  bit          idle_on;

  block_transposition_cipher_unit #(
    .MAX_BLOCK(MAX_BLOCK)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .char_in_i     (char_in_i),
    .end_of_line_i (end_of_line_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_out_o    (char_out_o),
    .block_last_o  (block_last_o),
    .length_error_o(length_error_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort on a hang.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned draw_gap();
    return idle_on ? $urandom_range(0, MAX_GAP) : 0;
  endfunction

  // Clamp the programmed length the way the unit does: 0 acts as 1, above max acts as max.
  function automatic int unsigned active_length(input logic [LEN_W-1:0] len);
    if (len == '0) begin
      return 1;
    end
    if (len > MAX_BLOCK) begin
      return MAX_BLOCK;
    end
    return len;
  endfunction

  function automatic logic [KEY_W-1:0] shuffled_key();
    logic [NIB_W-1:0] perm [KEY_NIB];
    logic [NIB_W-1:0] t;
    logic [KEY_W-1:0] key;
    int unsigned      i;
    int unsigned      j;
    for (i = 0; i < KEY_NIB; i++) begin
      perm[i] = NIB_W'(i);
    end
    for (i = KEY_NIB - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      t       = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (i = 0; i < KEY_NIB; i++) begin
      key[NIB_W*i +: NIB_W] = perm[i];
    end
    return key;
  endfunction

  // Advance the shadow state by one accepted item and queue the ciphertext it causes.
  function automatic void encipher_item(input logic [CHAR_W-1:0] ch, input logic eol);
    cipher_out_t      r;
    int unsigned      n;
    int unsigned      k;
    logic [NIB_W-1:0] src;
    if (eol) begin
      // A line ending on a partial block flags it and clears it; an empty block says nothing.
      if (shadow_fill != '0) begin
        shadow_fill = '0;
        r.ch   = '0;
        r.last = 1'b1;
        r.err  = 1'b1;
        pending_cipher.push_back(r);
      end
      return;
    end
    if (ch == SPACE_CHAR) begin
      return;
    end
    shadow_store[shadow_fill[NIB_W-1:0]] = ch;
    shadow_fill = shadow_fill + 1'b1;
    n = active_length(shadow_len);
    // A block already at or past a shrunk length still takes this character, then fires.
    if (shadow_fill < n) begin
      return;
    end
    for (k = 0; k < n; k++) begin
      src    = shadow_key[NIB_W*k +: NIB_W];
      r.ch   = shadow_store[src];
      r.last = (k + 1 == n);
      r.err  = 1'b0;
      pending_cipher.push_back(r);
    end
    shadow_fill = '0;
  endfunction

  // Present one item, hold it until accepted, then predict. Valid stays high on return
  // so back-to-back items need no gap.
  task automatic send_item(input logic [CHAR_W-1:0] ch, input logic eol);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    char_in_i     <= ch;
    end_of_line_i <= eol;
    do @(posedge clk_i); while (!in_ready_o);
    encipher_item(ch, eol);
  endtask

  // Drop valid, wait for every predicted item, then give the pipeline time to settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_cipher.size() != 0) @(posedge clk_i);
    repeat (DRAIN_SLACK) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_BLOCK_LENGTH) begin
      shadow_len = data[LEN_W-1:0];
    end else begin
      shadow_key = data;
    end
    @(posedge clk_i);
  endtask

  // Reset values: length 16, identity key. This block also writes every store entry,
  // so later keys may point anywhere.
  task automatic test_reset_identity();
    logic [CHAR_W-1:0] txt [16] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h21, 8'h1F, 8'h7F, 8'h80,
                                    8'h01, 8'hFE, 8'h41, 8'h7A, 8'h30, 8'h39, 8'h0A, 8'hC5};
    int unsigned i;
    for (i = 0; i < 16; i++) begin
      if (i == 4) begin
        send_item(SPACE_CHAR, 1'b0);
      end
      send_item(txt[i], 1'b0);
    end
    drain_results();
  endtask

  // Length 0 acts as 1; junk in the upper data bits is ignored.
  task automatic test_length_zero();
    write_reg(REG_BLOCK_LENGTH, 64'hFFFF_FFFF_FFFF_FFE0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    drain_results();
  endtask

  // Length above max acts as max; a line ending mid-block flags an error, an empty one does not.
  task automatic test_line_end_partial();
    write_reg(REG_BLOCK_LENGTH, 64'h0000_0000_0000_001F);
    write_reg(REG_KEY, 64'h0123_4567_89AB_CDEF);
    send_item(8'hC3, 1'b0);
    send_item(SPACE_CHAR, 1'b0);
    send_item(8'h3C, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'h5A, 1'b1);
    drain_results();
  endtask

  // Shrink the length under a partial block; the key repeats an index and reaches past
  // the block into data left from an earlier, longer block.
  task automatic test_shrink_mid_block();
    write_reg(REG_BLOCK_LENGTH, {{(CFG_DATA_W-LEN_W){1'b0}}, LEN_RESET});
    send_item(8'h11, 1'b0);
    send_item(8'h22, 1'b0);
    send_item(8'h33, 1'b0);
    drain_results();
    write_reg(REG_BLOCK_LENGTH, 64'd3);
    write_reg(REG_KEY, 64'hFFFF_FFFF_FFFF_FF33);
    send_item(8'h44, 1'b0);
    drain_results();
  endtask

  // Phases of random settings; mostly whole lines of random text, some cut short,
  // the rest noise with stray spaces and line ends.
  task automatic test_random_traffic();
    int unsigned           phase;
    int unsigned           counted;
    int unsigned           len;
    int unsigned           n;
    int unsigned           i;
    logic [CHAR_W-1:0]     ch;
    logic                  eol;
    logic [CFG_DATA_W-1:0] data;
    for (phase = 0; phase < PHASES; phase++) begin
      drain_results();
      idle_on = (phase % 3 != 1);
      data = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0: begin
          data[LEN_W-1:0] = '0;
        end
        1: begin
          data[LEN_W-1:0] = LEN_W'($urandom_range(MAX_BLOCK + 1, 31));
        end
        2: begin
          data[LEN_W-1:0] = LEN_W'(1);
        end
        3: begin
          data[LEN_W-1:0] = LEN_W'(MAX_BLOCK);
        end
        default: begin
          data[LEN_W-1:0] = LEN_W'($urandom_range(1, MAX_BLOCK));
        end
      endcase
      write_reg(REG_BLOCK_LENGTH, data);
      data = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : shuffled_key();
      write_reg(REG_KEY, data);
      len = active_length(shadow_len);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) begin
          n = $urandom_range(1, 12);
          for (i = 0; i < n; i++) begin
            ch  = ($urandom_range(0, 5) == 0) ? SPACE_CHAR : CHAR_W'($urandom);
            eol = ($urandom_range(0, 5) == 0);
            send_item(ch, eol);
            if (eol || ch != SPACE_CHAR) begin
              counted++;
            end
          end
        end else begin
          n = $urandom_range(1, 3) * len;
          if (len > 1 && $urandom_range(0, 4) == 0) begin
            n = n - $urandom_range(1, len - 1);
          end
          for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) begin
              send_item(SPACE_CHAR, 1'b0);
            end
            ch = CHAR_W'($urandom);
            if (ch == SPACE_CHAR) begin
              ch = ~ch;
            end
            send_item(ch, 1'b0);
            counted++;
          end
          send_item(CHAR_W'($urandom), 1'b1);
          counted++;
        end
      end
    end
    idle_on = 1'b1;
  endtask

  // Output side: stall a random number of cycles before each item, then hold ready.
  initial begin : result_sink
    int unsigned stall;
    @(posedge clk_i);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(rst_ni && out_valid_o && out_ready_i));
    end
  end

  // Compare each accepted item with the oldest prediction.
  always @(posedge clk_i) begin : check_result
    cipher_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_cipher.size() == 0) begin
        $display("%0t: unexpected item: expected none, actual char %02h last %b err %b",
                 $time, char_out_o, block_last_o, length_error_o);
        mismatches++;
      end else begin
        want = pending_cipher.pop_front();
        if (char_out_o !== want.ch) begin
          $display("%0t: char_out expected %02h, actual %02h", $time, want.ch, char_out_o);
          mismatches++;
        end
        if (block_last_o !== want.last) begin
          $display("%0t: block_last expected %b, actual %b", $time, want.last, block_last_o);
          mismatches++;
        end
        if (length_error_o !== want.err) begin
          $display("%0t: length_error expected %b, actual %b", $time, want.err,
                   length_error_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    char_in_i     <= '0;
    end_of_line_i <= 1'b0;
    out_ready_i   <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= REG_BLOCK_LENGTH;
    cfg_data_i    <= '0;
    mismatches  = 0;
    idle_on     = 1'b1;
    shadow_fill = '0;
    shadow_len  = LEN_RESET;
    shadow_key  = KEY_RESET;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_identity();
    test_length_zero();
    test_line_end_partial();
    test_shrink_mid_block();
    test_random_traffic();
    drain_results();

    if (mismatches == 0 && pending_cipher.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== block_transposition_cipher_unit.f =====
rtl/core/btc_pkg.sv
rtl/core/btc_front.sv
rtl/core/btc_queue.sv
rtl/core/btc_back.sv
rtl/core/block_transposition_cipher_unit.sv
sim/block_transposition_cipher_unit_tb.sv
